### rtl/dqne_pkg.sv
// ============================================================================
// dqne_pkg - shared types and constants for the DNS query name encoder
// Message layout constants, length limits, the command word passed from the
// front end to the byte sequencer, and the header byte table.
// ============================================================================
package dqne_pkg;

    localparam int OFF_W   = 9;      // byte offset width
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 6;      // label length, at most 63
    localparam int REG_W   = 16;
    localparam int STEP_W  = 5;

    localparam logic [BYTE_W-1:0] DOT_CHAR   = 8'h2E;
    localparam logic [OFF_W-1:0]  HEADER_LEN = 9'd12;
    localparam logic [OFF_W-1:0]  NAME_START = 9'd13;

    // name and label limits
    localparam logic [OFF_W-1:0]  MAX_NAME  = 9'd255;
    localparam logic [LEN_W-1:0]  MAX_LABEL = 6'd63;

    localparam logic [REG_W-1:0]  HDR_FLAGS   = 16'h0100;
    localparam logic [REG_W-1:0]  HDR_QDCOUNT = 16'h0001;
    localparam logic [REG_W-1:0]  QCLASS_IN   = 16'h0001;

    localparam logic [REG_W-1:0]  QUERY_ID_RST   = 16'd1028;
    localparam logic [REG_W-1:0]  QUERY_TYPE_RST = 16'd1;

    // configuration register indexes
    localparam logic CFG_QUERY_ID   = 1'b0;
    localparam logic CFG_QUERY_TYPE = 1'b1;

    // sequencer steps: 0..11 header, then body byte, then the tail
    localparam logic [STEP_W-1:0] STEP_HDR_FIRST = 5'd0;
    localparam logic [STEP_W-1:0] STEP_HDR_LAST  = 5'd11;
    localparam logic [STEP_W-1:0] STEP_BODY      = 5'd12;
    localparam logic [STEP_W-1:0] STEP_SLOT      = 5'd13;
    localparam logic [STEP_W-1:0] STEP_ROOT      = 5'd14;
    localparam logic [STEP_W-1:0] STEP_TYPE_HI   = 5'd15;
    localparam logic [STEP_W-1:0] STEP_TYPE_LO   = 5'd16;
    localparam logic [STEP_W-1:0] STEP_CLASS_HI  = 5'd17;
    localparam logic [STEP_W-1:0] STEP_CLASS_LO  = 5'd18;

    typedef struct packed {
        logic              hdr;       // emit the 12-byte header first
        logic              body;      // one byte from this character
        logic [OFF_W-1:0]  body_off;
        logic [BYTE_W-1:0] body_val;
        logic              fin;       // close the name and emit the tail
        logic [OFF_W-1:0]  slot;      // pending length slot after this char
        logic [LEN_W-1:0]  len;       // pending label length after this char
        logic [OFF_W-1:0]  pos;       // write position after this char
        logic              err;
    } t_cmd;

    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [3:0] idx,
                                                   input logic [REG_W-1:0] id);
        logic [BYTE_W-1:0] b;
        b = '0;
        unique case (idx)
            4'd0:    b = id[15:8];
            4'd1:    b = id[7:0];
            4'd2:    b = HDR_FLAGS[15:8];
            4'd3:    b = HDR_FLAGS[7:0];
            4'd4:    b = HDR_QDCOUNT[15:8];
            4'd5:    b = HDR_QDCOUNT[7:0];
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

### rtl/dqne_in_if.sv
// ============================================================================
// dqne_in_if - name character channel
// Valid/ready channel carrying one name character and its last-character flag.
// ============================================================================
interface dqne_in_if;
    logic                          valid;
    logic                          ready;
    logic [dqne_pkg::BYTE_W-1:0]   name_char;
    logic                          final_char;

    modport source (output valid, output name_char, output final_char, input ready);
    modport sink   (input valid, input name_char, input final_char, output ready);
endinterface

### rtl/dqne_out_if.sv
// ============================================================================
// dqne_out_if - message byte channel
// Valid/ready channel carrying one message byte with its offset and flags.
// ============================================================================
interface dqne_out_if;
    logic                          valid;
    logic                          ready;
    logic [dqne_pkg::OFF_W-1:0]    byte_offset;
    logic [dqne_pkg::BYTE_W-1:0]   byte_value;
    logic                          message_end;
    logic                          overlong;

    modport source (output valid, output byte_offset, output byte_value,
                    output message_end, output overlong, input ready);
    modport sink   (input valid, input byte_offset, input byte_value,
                    input message_end, input overlong, output ready);
endinterface

### rtl/dqne_front.sv
// ============================================================================
// dqne_front - name parser
// Tracks label length, write position and length slot per character and
// turns each accepted character into one command word for the sequencer.
// ============================================================================
module dqne_front #(
    parameter logic [dqne_pkg::OFF_W-1:0] MAX_NAME  = dqne_pkg::MAX_NAME,
    parameter logic [dqne_pkg::LEN_W-1:0] MAX_LABEL = dqne_pkg::MAX_LABEL
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_full,
    input  logic [dqne_pkg::BYTE_W-1:0]  i_name_char,
    input  logic                         i_final_char,
    output logic                         o_push,
    output dqne_pkg::t_cmd               o_cmd
);

    logic                        r_hdr_done;
    logic [dqne_pkg::OFF_W-1:0]  r_write_pos;
    logic [dqne_pkg::OFF_W-1:0]  r_slot;
    logic [dqne_pkg::LEN_W-1:0]  r_label_len;
    logic                        r_err;

    logic                        n_hdr_done;
    logic [dqne_pkg::OFF_W-1:0]  n_write_pos;
    logic [dqne_pkg::OFF_W-1:0]  n_slot;
    logic [dqne_pkg::LEN_W-1:0]  n_label_len;
    logic                        n_err;

    logic take;
    logic is_dot;
    logic room;
    logic acc;

    assign take   = i_valid && !i_full;
    assign is_dot = (i_name_char == dqne_pkg::DOT_CHAR);
    assign room   = (r_write_pos - dqne_pkg::NAME_START) < MAX_NAME;
    assign acc    = room && (is_dot || (r_label_len < MAX_LABEL));

    always_comb begin
        n_hdr_done  = 1'b1;
        n_write_pos = r_write_pos;
        n_slot      = r_slot;
        n_label_len = r_label_len;
        n_err       = r_err || !acc;

        o_cmd          = '0;
        o_cmd.hdr      = !r_hdr_done;
        o_cmd.body     = acc;
        o_cmd.body_off = r_write_pos;
        o_cmd.body_val = i_name_char;

        if (acc) begin
            n_write_pos = r_write_pos + 1'b1;
            if (is_dot) begin
                o_cmd.body_off = r_slot;
                o_cmd.body_val = dqne_pkg::BYTE_W'(r_label_len);
                n_slot         = r_write_pos;
                n_label_len    = '0;
            end else begin
                n_label_len = r_label_len + 1'b1;
            end
        end

        o_cmd.fin  = i_final_char;
        o_cmd.slot = n_slot;
        o_cmd.len  = n_label_len;
        o_cmd.pos  = n_write_pos;
        o_cmd.err  = n_err;

        // end of name: everything back to its start values
        if (i_final_char) begin
            n_hdr_done  = 1'b0;
            n_write_pos = dqne_pkg::NAME_START;
            n_slot      = dqne_pkg::HEADER_LEN;
            n_label_len = '0;
            n_err       = 1'b0;
        end
    end

    // a dropped character after the header with no close makes no bytes
    assign o_push = take && (o_cmd.hdr || o_cmd.body || o_cmd.fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_done  <= 1'b0;
            r_write_pos <= dqne_pkg::NAME_START;
            r_slot      <= dqne_pkg::HEADER_LEN;
            r_label_len <= '0;
            r_err       <= 1'b0;
        end else if (take) begin
            r_hdr_done  <= n_hdr_done;
            r_write_pos <= n_write_pos;
            r_slot      <= n_slot;
            r_label_len <= n_label_len;
            r_err       <= n_err;
        end
    end

endmodule

### rtl/dqne_fifo.sv
// ============================================================================
// dqne_fifo - command queue
// Two-entry queue of command words between the parser and the sequencer.
// ============================================================================
module dqne_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dqne_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output dqne_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);

    dqne_pkg::t_cmd r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_cnt;

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/dqne_back.sv
// ============================================================================
// dqne_back - byte sequencer
// Expands the head command into header, body and tail bytes, one per cycle
// while the output is not stalled, into a registered output word.
// ============================================================================
module dqne_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  dqne_pkg::t_cmd               i_cmd,
    output logic                         o_pop,
    input  logic [dqne_pkg::REG_W-1:0]   i_query_id,
    input  logic [dqne_pkg::REG_W-1:0]   i_query_type,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dqne_pkg::OFF_W-1:0]   o_byte_offset,
    output logic [dqne_pkg::BYTE_W-1:0]  o_byte_value,
    output logic                         o_message_end,
    output logic                         o_overlong
);

    logic [dqne_pkg::STEP_W-1:0]  r_step;
    logic [dqne_pkg::STEP_W-1:0]  eff;
    logic                         last;
    logic                         load;
    logic                         emit;
    logic [dqne_pkg::OFF_W-1:0]   off;
    logic [dqne_pkg::BYTE_W-1:0]  val;

    logic                         r_valid;
    logic [dqne_pkg::OFF_W-1:0]   r_off;
    logic [dqne_pkg::BYTE_W-1:0]  r_val;
    logic                         r_end;
    logic                         r_err;

    // skip the parts this command does not have
    always_comb begin
        eff = r_step;
        if ((eff < dqne_pkg::STEP_BODY) && !i_cmd.hdr) begin
            eff = dqne_pkg::STEP_BODY;
        end
        if ((eff == dqne_pkg::STEP_BODY) && !i_cmd.body) begin
            eff = dqne_pkg::STEP_SLOT;
        end
    end

    assign last = ((eff == dqne_pkg::STEP_HDR_LAST) && !i_cmd.body && !i_cmd.fin)
               || ((eff == dqne_pkg::STEP_BODY) && !i_cmd.fin)
               || (eff == dqne_pkg::STEP_CLASS_LO);

    assign load  = !r_valid || i_ready;
    assign emit  = i_cmd_valid && load;
    assign o_pop = emit && last;

    always_comb begin
        off = dqne_pkg::OFF_W'(eff);
        val = dqne_pkg::hdr_byte(eff[3:0], i_query_id);
        unique case (eff)
            dqne_pkg::STEP_BODY: begin
                off = i_cmd.body_off;
                val = i_cmd.body_val;
            end
            dqne_pkg::STEP_SLOT: begin
                off = i_cmd.slot;
                val = dqne_pkg::BYTE_W'(i_cmd.len);
            end
            dqne_pkg::STEP_ROOT: begin
                off = i_cmd.pos;
                val = '0;
            end
            dqne_pkg::STEP_TYPE_HI: begin
                off = i_cmd.pos + 9'd1;
                val = i_query_type[15:8];
            end
            dqne_pkg::STEP_TYPE_LO: begin
                off = i_cmd.pos + 9'd2;
                val = i_query_type[7:0];
            end
            dqne_pkg::STEP_CLASS_HI: begin
                off = i_cmd.pos + 9'd3;
                val = dqne_pkg::QCLASS_IN[15:8];
            end
            dqne_pkg::STEP_CLASS_LO: begin
                off = i_cmd.pos + 9'd4;
                val = dqne_pkg::QCLASS_IN[7:0];
            end
            default: begin
                off = dqne_pkg::OFF_W'(eff);
                val = dqne_pkg::hdr_byte(eff[3:0], i_query_id);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= dqne_pkg::STEP_HDR_FIRST;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_step  <= last ? dqne_pkg::STEP_HDR_FIRST : eff + 1'b1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_off <= off;
            r_val <= val;
            r_end <= (eff == dqne_pkg::STEP_CLASS_LO);
            r_err <= i_cmd.err;
        end
    end

    assign o_valid       = r_valid;
    assign o_byte_offset = r_off;
    assign o_byte_value  = r_val;
    assign o_message_end = r_end;
    assign o_overlong    = r_err;

endmodule

### rtl/dns_query_name_encoder_core.sv
// ============================================================================
// dns_query_name_encoder_core - DNS query message builder
// Turns a dotted name, one character per word, into offset-tagged bytes of a
// DNS query message: header, length-prefixed labels, root, type and class.
// ============================================================================
//  channel   dir  words                               fields
//  i_in      in   one name character                  name_char, final_char
//  o_out     out  one message byte                    byte_offset, byte_value,
//                                                      message_end, overlong
//  i_cfg_*   in   register write (0 id, 1 qtype)      i_cfg_idx, i_cfg_data
//
//  An ordinary character gives one byte; the sequencer sends one byte out per cycle
//  while the output is not stalled. The first character of a name adds the 12 header
//  bytes and the last adds the 6 tail bytes; the two-entry command queue takes input
//  while those bursts drain. Reset is synchronous and clears all control state; the
//  registers return to id 1028 and type 1.
// ============================================================================
module dns_query_name_encoder_core #(
    parameter logic [dqne_pkg::OFF_W-1:0] MAX_NAME  = dqne_pkg::MAX_NAME,
    parameter logic [dqne_pkg::LEN_W-1:0] MAX_LABEL = dqne_pkg::MAX_LABEL
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    dqne_in_if.sink                      i_in,
    dqne_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [dqne_pkg::REG_W-1:0]   i_cfg_data
);

    logic [dqne_pkg::REG_W-1:0] r_query_id;
    logic [dqne_pkg::REG_W-1:0] r_query_type;

    logic           push;
    logic           full;
    logic           cmd_valid;
    logic           pop;
    dqne_pkg::t_cmd front_cmd;
    dqne_pkg::t_cmd head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_id   <= dqne_pkg::QUERY_ID_RST;
            r_query_type <= dqne_pkg::QUERY_TYPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dqne_pkg::CFG_QUERY_ID:   r_query_id   <= i_cfg_data;
                dqne_pkg::CFG_QUERY_TYPE: r_query_type <= i_cfg_data;
                default:                  r_query_id   <= r_query_id;
            endcase
        end
    end

    assign i_in.ready = !full;

    dqne_front #(
        .MAX_NAME  (MAX_NAME),
        .MAX_LABEL (MAX_LABEL)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_full       (full),
        .i_name_char  (i_in.name_char),
        .i_final_char (i_in.final_char),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    dqne_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    dqne_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .i_query_id    (r_query_id),
        .i_query_type  (r_query_type),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_byte_offset (o_out.byte_offset),
        .o_byte_value  (o_out.byte_value),
        .o_message_end (o_out.message_end),
        .o_overlong    (o_out.overlong)
    );

endmodule

### rtl/dqne_checker.sv
// ============================================================================
// dqne_checker - port-level checks for the query name encoder
// Watches the byte channel: reset, holding under stall and message framing.
// ============================================================================
module dqne_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [dqne_pkg::OFF_W-1:0]   i_out_byte_offset,
    input  logic [dqne_pkg::BYTE_W-1:0]  i_out_byte_value,
    input  logic                         i_out_message_end
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped under stall");

    // last word of a message is the low class byte, at offset 18 or later
    a_end_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_message_end |->
            i_out_byte_value == dqne_pkg::QCLASS_IN[7:0] && i_out_byte_offset >= 9'd18)
        else $error("bad message end word");

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_byte_offset <= 9'd272)
        else $error("byte offset out of range");

endmodule

bind dns_query_name_encoder_core dqne_checker u_dqne_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_byte_offset (o_out.byte_offset),
    .i_out_byte_value  (o_out.byte_value),
    .i_out_message_end (o_out.message_end)
);

### tb/tb_dns_query_name_encoder_core.sv
// ============================================================================
// tb_dns_query_name_encoder_core - testbench for the DNS query name encoder
// Sends dotted names one character per word. A behavioral model predicts
// every message byte: header, label lengths, characters, root, type and class.
// Accepted bytes are checked in order against those predictions. The tests
// cover edge-case names, register settings, overlong labels and names,
// output back-pressure and random names, with random idling on both channels.
// ============================================================================
module tb_dns_query_name_encoder_core;

    localparam int HALF_PERIOD   = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 40;
    localparam int MAX_REPORTS   = 10;
    localparam int IDLE_PCT      = 18;

    // header bytes 2..11: flags, qdcount, then zero counts
    localparam logic [79:0] HDR_FIXED = {dqne_pkg::HDR_FLAGS, dqne_pkg::HDR_QDCOUNT, 48'h0};

    typedef struct packed {
        logic [dqne_pkg::OFF_W-1:0]  off;
        logic [dqne_pkg::BYTE_W-1:0] val;
        logic                        msg_end;
        logic                        overlong;
    } t_msg_byte;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic                       i_cfg_idx;
    logic [dqne_pkg::REG_W-1:0] i_cfg_data;

    dqne_in_if  name_ch();
    dqne_out_if msg_out();

    dns_query_name_encoder_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (name_ch),
        .o_out      (msg_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // encoder model state
    logic                       hdr_sent  = 1'b0;
    logic [dqne_pkg::OFF_W-1:0] wr_pos    = dqne_pkg::NAME_START;
    logic [dqne_pkg::OFF_W-1:0] len_slot  = dqne_pkg::HEADER_LEN;
    logic [6:0]                 label_len = '0;
    logic                       err_seen  = 1'b0;
    logic [dqne_pkg::REG_W-1:0] qid_reg;
    logic [dqne_pkg::REG_W-1:0] qtype_reg;

    t_msg_byte   bytes_due[$];
    logic [7:0]  name_buf[$];
    int          mismatches   = 0;
    int          items_sent;
    int          stall_cycles = 0;
    int          hold_left    = 0;
    bit          hold_used    = 1'b0;
    bit          hold_req;
    bit          in_idle_on;
    bit          out_idle_on;

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void clear_name();
        hdr_sent  = 1'b0;
        wr_pos    = dqne_pkg::NAME_START;
        len_slot  = dqne_pkg::HEADER_LEN;
        label_len = '0;
        err_seen  = 1'b0;
    endfunction

    function automatic void push_byte(input logic [dqne_pkg::OFF_W-1:0] off,
                                      input logic [7:0] val, input logic msg_end);
        t_msg_byte b;
        b.off      = off;
        b.val      = val;
        b.msg_end  = msg_end;
        b.overlong = err_seen;
        bytes_due.push_back(b);
    endfunction

    function automatic void encode_char(input logic [7:0] ch, input logic fin);
        logic                       is_dot;
        logic                       take;
        logic [dqne_pkg::OFF_W-1:0] p;
        is_dot = (ch == dqne_pkg::DOT_CHAR);
        take   = (int'(wr_pos) - int'(dqne_pkg::NAME_START) < int'(dqne_pkg::MAX_NAME))
                 && (is_dot || label_len < dqne_pkg::MAX_LABEL);
        if (!take)
            err_seen = 1'b1;
        if (!hdr_sent) begin
            push_byte(9'd0, qid_reg[15:8], 1'b0);
            push_byte(9'd1, qid_reg[7:0], 1'b0);
            for (int i = 0; i < 10; i++)
                push_byte(9'(i + 2), HDR_FIXED[79-8*i -: 8], 1'b0);
            hdr_sent = 1'b1;
        end
        if (take) begin
            if (is_dot) begin
                push_byte(len_slot, 8'(label_len), 1'b0);
                len_slot  = wr_pos;
                label_len = '0;
            end else begin
                push_byte(wr_pos, ch, 1'b0);
                label_len = label_len + 7'd1;
            end
            wr_pos = wr_pos + 9'd1;
        end
        if (fin) begin
            // close last label, root byte, qtype, class
            p = wr_pos;
            push_byte(len_slot, 8'(label_len), 1'b0);
            push_byte(p, 8'h00, 1'b0);
            push_byte(p + 9'd1, qtype_reg[15:8], 1'b0);
            push_byte(p + 9'd2, qtype_reg[7:0], 1'b0);
            push_byte(p + 9'd3, dqne_pkg::QCLASS_IN[15:8], 1'b0);
            push_byte(p + 9'd4, dqne_pkg::QCLASS_IN[7:0], 1'b1);
            clear_name();
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    // receiver: one long hold on request, else random or steady ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            msg_out.ready <= 1'b0;
        end else begin
            if (hold_req && !hold_used) begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                msg_out.ready <= 1'b0;
            end else if (out_idle_on) begin
                msg_out.ready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                msg_out.ready <= 1'b1;
            end
        end
    end

    // predict on accepted characters, check accepted bytes, watch for a hang
    always @(posedge i_clk) begin : mon
        t_msg_byte want;
        logic      took;
        took = 1'b0;
        if (i_rst_n) begin
            if (name_ch.valid === 1'b1 && name_ch.ready === 1'b1) begin
                encode_char(name_ch.name_char, name_ch.final_char);
                took = 1'b1;
            end
            if (msg_out.valid === 1'b1 && msg_out.ready === 1'b1) begin
                took = 1'b1;
                if (bytes_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected byte off=%0d val=%02h end=%b ovl=%b",
                        msg_out.byte_offset, msg_out.byte_value, msg_out.message_end,
                        msg_out.overlong));
                end else begin
                    want = bytes_due.pop_front();
                    if ({msg_out.byte_offset, msg_out.byte_value, msg_out.message_end,
                         msg_out.overlong} !== want)
                        note_mismatch($sformatf(
                            "exp off=%0d val=%02h end=%b ovl=%b, got off=%0d val=%02h end=%b ovl=%b",
                            want.off, want.val, want.msg_end, want.overlong,
                            msg_out.byte_offset, msg_out.byte_value, msg_out.message_end,
                            msg_out.overlong));
                end
            end
            if (took) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    function automatic logic [7:0] label_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == dqne_pkg::DOT_CHAR);
        return c;
    endfunction

    function automatic void add_label(input int n);
        for (int i = 0; i < n; i++)
            name_buf.push_back(label_char());
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(s[i]);
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic fin);
        while (in_idle_on && $urandom_range(99) < IDLE_PCT) begin
            name_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        name_ch.valid      <= 1'b1;
        name_ch.name_char  <= ch;
        name_ch.final_char <= fin;
        do @(posedge i_clk); while (name_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic send_name();
        for (int i = 0; i < name_buf.size(); i++)
            send_char(name_buf[i], i == name_buf.size() - 1);
        name_buf.delete();
    endtask

    // drop valid, wait out every predicted byte plus the pipeline tail
    task automatic quiesce();
        name_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [dqne_pkg::REG_W-1:0] data);
        quiesce();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == dqne_pkg::CFG_QUERY_ID)
            qid_reg = data;
        else
            qtype_reg = data;
    endtask

    task automatic test_directed();
        add_str("a");                       // one-char name, full burst
        send_name();
        name_buf.push_back(8'h00);
        name_buf.push_back(8'hFF);
        send_name();
        add_str(".x");                      // leading dot
        send_name();
        add_str("a..b");                    // repeated dots
        send_name();
        add_str("c.");                      // trailing dot
        send_name();
        add_str(".");
        send_name();
        name_buf.push_back(8'h7F);
        name_buf.push_back(8'h80);
        add_str(".");
        name_buf.push_back(8'h01);
        send_name();
    endtask

    task automatic test_config();
        write_reg(dqne_pkg::CFG_QUERY_ID, 16'h0000);
        write_reg(dqne_pkg::CFG_QUERY_TYPE, 16'h0000);
        add_str("ab.c");
        send_name();
        write_reg(dqne_pkg::CFG_QUERY_ID, 16'hFFFF);
        write_reg(dqne_pkg::CFG_QUERY_TYPE, 16'hFFFF);
        add_str("z");
        send_name();
        write_reg(dqne_pkg::CFG_QUERY_ID, 16'h8001);
        write_reg(dqne_pkg::CFG_QUERY_TYPE, 16'h001C);
        add_str("w.");
        send_name();
    endtask

    task automatic test_long_label();
        add_label(63);
        add_label(2);                       // dropped, label full
        add_str(".q");
        send_name();
        add_str("ok");                      // flag must be clear again
        send_name();
    endtask

    // also the long stretch with no idling on either side
    task automatic test_long_name();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        for (int k = 0; k < 5; k++) begin
            add_label(50);
            if (k < 4)
                add_str(".");
        end
        add_label(1);                       // fills the name exactly
        add_str(".");                       // dot dropped, name full
        add_label(1);                       // final dropped
        send_name();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 4; k++) begin
            add_label(4);
            add_str(".");
            add_label(3);
            send_name();
        end
    endtask

    task automatic test_random();
        int start;
        int pick;
        int nlab;
        int names;
        logic [dqne_pkg::REG_W-1:0] val;
        start = items_sent;
        names = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                nlab = $urandom_range(4, 1);
                for (int l = 0; l < nlab; l++) begin
                    add_label($urandom_range(12, 1));
                    if (l < nlab - 1)
                        add_str(".");
                end
                if ($urandom_range(9) == 0)
                    add_str(".");
            end else if (pick < 95) begin
                nlab = $urandom_range(8, 1);
                for (int i = 0; i < nlab; i++)
                    name_buf.push_back(($urandom_range(3) == 0) ? dqne_pkg::DOT_CHAR
                                                                : 8'($urandom_range(255)));
            end else begin
                add_label($urandom_range(66, 60));
                add_str(".");
                add_label($urandom_range(3, 1));
            end
            send_name();
            names++;
            if (names % 4 == 0) begin
                case ($urandom_range(3))
                    0:       val = 16'h0000;
                    1:       val = 16'hFFFF;
                    default: val = 16'($urandom);
                endcase
                write_reg($urandom_range(1) ? dqne_pkg::CFG_QUERY_TYPE
                                            : dqne_pkg::CFG_QUERY_ID, val);
            end
        end
    endtask

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = dqne_pkg::CFG_QUERY_ID;
        i_cfg_data         = '0;
        name_ch.valid      = 1'b0;
        name_ch.name_char  = '0;
        name_ch.final_char = 1'b0;
        items_sent   = 0;
        hold_req     = 1'b0;
        in_idle_on   = 1'b0;
        out_idle_on  = 1'b0;
        qid_reg   = dqne_pkg::QUERY_ID_RST;
        qtype_reg = dqne_pkg::QUERY_TYPE_RST;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;

        test_directed();
        test_config();
        test_long_label();
        test_long_name();
        test_backpressure();
        test_random();
        quiesce();

        if (mismatches == 0 && bytes_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
